/* src/pssf_pkg.sv */
`default_nettype none
package pssf_pkg;

    // field widths
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // saturation limit of the kept counter
    localparam int MAX_ITEMS = 1024;

    // one root bit per cell
    localparam int NUM_CELLS = VALUE_W / 2;
    localparam int ROOT_W    = NUM_CELLS;
    localparam int REM_W     = ROOT_W + 1;

    // data handed from one cell to the next
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               last_item;
        logic [VALUE_W-1:0] rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } t_cell_data;

endpackage
`default_nettype wire

/* src/perfect_square_stream_filter.sv */
// Perfect-square filter for a stream of signed 32-bit values. Positive perfect
// squares are dropped; every other value comes out with its index among the kept
// values of the current array, and an item flagged last_item adds a summary
// result (kept count, saturating at 1024, and a flag if none was kept) after it.
// The block works on one item at a time: the item walks a row of 16 root cells,
// one root bit per cell and cycle, then is sorted into the output register, and
// only then is the next item accepted, so a stalled output side holds the input.
// The output register and a pending summary slot let the next item enter while
// earlier results still wait to be taken.
`default_nettype none
module perfect_square_stream_filter (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire signed [pssf_pkg::VALUE_W-1:0]  i_value,
    input  wire                                 i_last_item,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic signed [pssf_pkg::VALUE_W-1:0] o_value_out,
    output logic [pssf_pkg::INDEX_W-1:0]        o_kept_index,
    output logic                                o_is_summary,
    output logic [pssf_pkg::COUNT_W-1:0]        o_kept_count,
    output logic                                o_none_left,
    output logic                                o_run_end
);

    localparam logic [pssf_pkg::COUNT_W-1:0] MaxCount = pssf_pkg::COUNT_W'(pssf_pkg::MAX_ITEMS);
    localparam logic [pssf_pkg::COUNT_W-1:0] MaxIndex =
        pssf_pkg::COUNT_W'(pssf_pkg::MAX_ITEMS - 1);

    pssf_pkg::t_cell_data w_chain_in;
    pssf_pkg::t_cell_data w_chain_out;
    logic                 w_in_xfer;
    logic                 w_out_xfer;
    logic                 w_load;
    logic                 w_square;

    logic                         r_busy,      n_busy;
    logic                         r_hold_v,    n_hold_v;
    logic [pssf_pkg::VALUE_W-1:0] r_hold_value;
    logic                         r_hold_last;
    logic                         r_hold_sq;
    logic [pssf_pkg::COUNT_W-1:0] r_kept,      n_kept;
    logic                         r_out_v,     n_out_v;
    logic [pssf_pkg::VALUE_W-1:0] r_value_out, n_value_out;
    logic [pssf_pkg::INDEX_W-1:0] r_kept_index, n_kept_index;
    logic                         r_is_summary, n_is_summary;
    logic [pssf_pkg::COUNT_W-1:0] r_kept_count, n_kept_count;
    logic                         r_none_left, n_none_left;
    logic                         r_run_end,   n_run_end;
    logic                         r_sum_pend,  n_sum_pend;
    logic [pssf_pkg::COUNT_W-1:0] r_sum_count, n_sum_count;
    logic [pssf_pkg::COUNT_W-1:0] w_kept_inc;
    logic [pssf_pkg::COUNT_W-1:0] w_idx_sat;

    // input transfer and chain feed
    assign o_stall   = r_busy;
    assign w_in_xfer = i_valid && !r_busy;

    always_comb begin
        w_chain_in.valid     = w_in_xfer;
        w_chain_in.value     = i_value;
        w_chain_in.last_item = i_last_item;
        w_chain_in.rad       = i_value;
        w_chain_in.rem       = '0;
        w_chain_in.root      = '0;
    end

    pssf_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_chain_in),
        .o_data  (w_chain_out)
    );

    // positive and zero remainder means perfect square
    assign w_square = !w_chain_out.value[pssf_pkg::VALUE_W-1]
                      && (w_chain_out.value != '0)
                      && (w_chain_out.rem == '0);

    // hold register behind the last cell
    always_ff @(posedge i_clk) begin
        if (w_chain_out.valid) begin
            r_hold_value <= w_chain_out.value;
            r_hold_last  <= w_chain_out.last_item;
            r_hold_sq    <= w_square;
        end
    end

    // counter arithmetic with saturation
    assign w_kept_inc = (r_kept < MaxCount) ? r_kept + 1'b1 : r_kept;
    assign w_idx_sat  = (r_kept > MaxIndex) ? MaxIndex : r_kept;

    assign w_out_xfer = r_out_v && !i_stall;
    assign w_load     = r_hold_v && (!r_out_v || (w_out_xfer && !r_sum_pend));

    // output queue: element result, then pending summary
    always_comb begin
        n_busy       = r_busy;
        n_hold_v     = r_hold_v;
        n_kept       = r_kept;
        n_out_v      = r_out_v;
        n_value_out  = r_value_out;
        n_kept_index = r_kept_index;
        n_is_summary = r_is_summary;
        n_kept_count = r_kept_count;
        n_none_left  = r_none_left;
        n_run_end    = r_run_end;
        n_sum_pend   = r_sum_pend;
        n_sum_count  = r_sum_count;

        if (w_in_xfer) begin
            n_busy = 1'b1;
        end
        if (w_chain_out.valid) begin
            n_hold_v = 1'b1;
        end

        if (w_out_xfer) begin
            if (r_sum_pend) begin
                n_value_out  = '0;
                n_kept_index = '0;
                n_is_summary = 1'b1;
                n_kept_count = r_sum_count;
                n_none_left  = (r_sum_count == '0);
                n_run_end    = 1'b1;
                n_sum_pend   = 1'b0;
            end else begin
                n_out_v = 1'b0;
            end
        end

        if (w_load) begin
            n_busy   = 1'b0;
            n_hold_v = 1'b0;
            if (!r_hold_sq) begin
                n_out_v      = 1'b1;
                n_value_out  = r_hold_value;
                n_kept_index = w_idx_sat[pssf_pkg::INDEX_W-1:0];
                n_is_summary = 1'b0;
                n_kept_count = '0;
                n_none_left  = 1'b0;
                n_run_end    = !r_hold_last;
                n_kept       = w_kept_inc;
                if (r_hold_last) begin
                    n_sum_pend  = 1'b1;
                    n_sum_count = w_kept_inc;
                    n_kept      = '0;
                end
            end else if (r_hold_last) begin
                n_out_v      = 1'b1;
                n_value_out  = '0;
                n_kept_index = '0;
                n_is_summary = 1'b1;
                n_kept_count = r_kept;
                n_none_left  = (r_kept == '0);
                n_run_end    = 1'b1;
                n_kept       = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_hold_v   <= 1'b0;
            r_kept     <= '0;
            r_out_v    <= 1'b0;
            r_sum_pend <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_hold_v   <= n_hold_v;
            r_kept     <= n_kept;
            r_out_v    <= n_out_v;
            r_sum_pend <= n_sum_pend;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_value_out  <= n_value_out;
        r_kept_index <= n_kept_index;
        r_is_summary <= n_is_summary;
        r_kept_count <= n_kept_count;
        r_none_left  <= n_none_left;
        r_run_end    <= n_run_end;
        r_sum_count  <= n_sum_count;
    end

    assign o_valid      = r_out_v;
    assign o_value_out  = r_value_out;
    assign o_kept_index = r_kept_index;
    assign o_is_summary = r_is_summary;
    assign o_kept_count = r_kept_count;
    assign o_none_left  = r_none_left;
    assign o_run_end    = r_run_end;

    // a token leaves the chain only for an item in flight
    a_chain_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain_out.valid |-> r_busy)
        else $error("chain output without item in flight");

    // held result belongs to the item in flight
    a_hold_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> r_busy)
        else $error("hold register valid while idle");

    // a pending summary always sits behind a shown element result
    a_sum_behind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_pend |-> (r_out_v && !r_is_summary && !r_run_end))
        else $error("pending summary without element result");

    // summary flag agrees with its count
    a_none_left : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_is_summary) |-> (r_none_left == (r_kept_count == '0)))
        else $error("none_left disagrees with kept_count");

    // accepted item blocks the input on the next cycle
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_busy)
        else $error("input not stalled after transfer");

endmodule
`default_nettype wire

/* src/pssf_cell.sv */
`default_nettype none
module pssf_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pssf_pkg::t_cell_data i_data,
    output pssf_pkg::t_cell_data o_data
);

    logic [pssf_pkg::REM_W+1:0] w_cur;
    logic [pssf_pkg::REM_W+1:0] w_trial;
    logic [pssf_pkg::REM_W+1:0] w_diff;
    logic                       w_ge;
    pssf_pkg::t_cell_data       r_data;
    pssf_pkg::t_cell_data       n_data;

    // one step of the restoring square root: bring down two bits, try root*4+1
    always_comb begin
        w_cur   = {i_data.rem, i_data.rad[pssf_pkg::VALUE_W-1 -: 2]};
        w_trial = {1'b0, i_data.root, 2'b01};
        w_ge    = (w_cur >= w_trial);
        w_diff  = w_cur - w_trial;
        n_data  = i_data;
        n_data.rad  = {i_data.rad[pssf_pkg::VALUE_W-3:0], 2'b00};
        n_data.rem  = w_ge ? w_diff[pssf_pkg::REM_W-1:0] : w_cur[pssf_pkg::REM_W-1:0];
        n_data.root = {i_data.root[pssf_pkg::ROOT_W-2:0], w_ge};
    end

    // payload moves every cycle, only the token bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= {1'b0, n_data.value, n_data.last_item, n_data.rad,
                       n_data.rem, n_data.root};
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

/* src/pssf_chain.sv */
`default_nettype none
module pssf_chain (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pssf_pkg::t_cell_data i_data,
    output pssf_pkg::t_cell_data o_data
);

    pssf_pkg::t_cell_data w_link [0:pssf_pkg::NUM_CELLS];

    assign w_link[0] = i_data;

    // row of root cells, most significant root bit first
    for (genvar g = 0; g < pssf_pkg::NUM_CELLS; g++) begin : g_cell
        pssf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_data  (w_link[g]),
            .o_data  (w_link[g+1])
        );
    end

    assign o_data = w_link[pssf_pkg::NUM_CELLS];

endmodule
`default_nettype wire

/* sim/pssf_checker.sv */
`timescale 1ns / 1ps
module pssf_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input channel
    input  wire                                i_in_valid,
    input  wire                                i_in_stall,
    input  wire [pssf_pkg::VALUE_W-1:0]        i_value,
    input  wire                                i_last_item,
    // output channel
    input  wire                                i_out_valid,
    input  wire                                i_out_stall,
    input  wire [pssf_pkg::VALUE_W-1:0]        i_value_out,
    input  wire [pssf_pkg::INDEX_W-1:0]        i_kept_index,
    input  wire                                i_is_summary,
    input  wire [pssf_pkg::COUNT_W-1:0]        i_kept_count,
    input  wire                                i_none_left,
    input  wire                                i_run_end,
    output int                                 o_errors,
    output int                                 o_pending
);

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [pssf_pkg::VALUE_W-1:0] value_out;
        logic [pssf_pkg::INDEX_W-1:0] kept_index;
        logic                         is_summary;
        logic [pssf_pkg::COUNT_W-1:0] kept_count;
        logic                         none_left;
        logic                         run_end;
    } t_filter_result;

    t_filter_result               pending_results[$];
    logic [pssf_pkg::COUNT_W-1:0] kept_so_far = '0;

    // true for a strictly positive value that is an exact square
    function automatic bit is_pos_square(logic [pssf_pkg::VALUE_W-1:0] v);
        logic [15:0]       root;
        logic [15:0]       trial;
        longint unsigned   sq;
        if (v == '0 || v[pssf_pkg::VALUE_W-1])
            return 1'b0;
        root = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            sq = longint'(trial) * longint'(trial);
            if (sq <= longint'(v))
                root = trial;
        end
        sq = longint'(root) * longint'(root);
        return sq == longint'(v);
    endfunction

    // work out the results one accepted element causes
    task automatic predict_filter(logic [pssf_pkg::VALUE_W-1:0] v, logic last);
        t_filter_result r;
        if (!is_pos_square(v)) begin
            r = '0;
            r.value_out  = v;
            r.kept_index = (kept_so_far > pssf_pkg::MAX_ITEMS - 1) ?
                           pssf_pkg::INDEX_W'(pssf_pkg::MAX_ITEMS - 1) :
                           kept_so_far[pssf_pkg::INDEX_W-1:0];
            r.run_end    = !last;
            pending_results.push_back(r);
            if (kept_so_far < pssf_pkg::MAX_ITEMS)
                kept_so_far = kept_so_far + 1'b1;
        end
        if (last) begin
            r = '0;
            r.is_summary = 1'b1;
            r.kept_count = kept_so_far;
            r.none_left  = (kept_so_far == '0);
            r.run_end    = 1'b1;
            pending_results.push_back(r);
            kept_so_far = '0;
        end
    endtask

    task automatic log_mismatch(string kind, t_filter_result want, t_filter_result got);
        o_errors = o_errors + 1;
        if (o_errors <= MAX_SHOWN) begin
            $display("%0t checker: %s", $realtime, kind);
            $display("    expected val=%0d idx=%0d sum=%0b cnt=%0d none=%0b end=%0b",
                     $signed(want.value_out), want.kept_index, want.is_summary,
                     want.kept_count, want.none_left, want.run_end);
            $display("    actual   val=%0d idx=%0d sum=%0b cnt=%0d none=%0b end=%0b",
                     $signed(got.value_out), got.kept_index, got.is_summary,
                     got.kept_count, got.none_left, got.run_end);
        end
    endtask

    // compare each output transfer, then predict from each input transfer
    always @(posedge i_clk) begin : watch
        t_filter_result got;
        t_filter_result want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                got.value_out  = i_value_out;
                got.kept_index = i_kept_index;
                got.is_summary = i_is_summary;
                got.kept_count = i_kept_count;
                got.none_left  = i_none_left;
                got.run_end    = i_run_end;
                if (pending_results.size() == 0) begin
                    log_mismatch("result with nothing expected", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.value_out  !== want.value_out  ||
                        got.kept_index !== want.kept_index ||
                        got.is_summary !== want.is_summary ||
                        got.kept_count !== want.kept_count ||
                        got.none_left  !== want.none_left  ||
                        got.run_end    !== want.run_end)
                        log_mismatch("result mismatch", want, got);
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_filter(i_value, i_last_item);
            o_pending <= pending_results.size();
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;

    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 300;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic [pssf_pkg::VALUE_W-1:0]  i_value     = '0;
    logic                          i_last_item = 1'b0;
    logic                          i_stall     = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic [pssf_pkg::VALUE_W-1:0]  o_value_out;
    logic [pssf_pkg::INDEX_W-1:0]  o_kept_index;
    logic                          o_is_summary;
    logic [pssf_pkg::COUNT_W-1:0]  o_kept_count;
    logic                          o_none_left;
    logic                          o_run_end;

    int errors;
    int pending;
    int sent      = 0;
    int idle_run  = 0;
    bit tx_quiet  = 1'b0;
    bit rx_quiet  = 1'b0;
    bit hold_go   = 1'b0;

    always #1 i_clk = ~i_clk;

    perfect_square_stream_filter u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_last_item  (i_last_item),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value_out  (o_value_out),
        .o_kept_index (o_kept_index),
        .o_is_summary (o_is_summary),
        .o_kept_count (o_kept_count),
        .o_none_left  (o_none_left),
        .o_run_end    (o_run_end)
    );

    pssf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_value      (i_value),
        .i_last_item  (i_last_item),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_value_out  (o_value_out),
        .i_kept_index (o_kept_index),
        .i_is_summary (o_is_summary),
        .i_kept_count (o_kept_count),
        .i_none_left  (o_none_left),
        .i_run_end    (o_run_end),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    // offer one element, with an optional idle burst first, until it transfers
    task automatic send_item(logic [pssf_pkg::VALUE_W-1:0] v, bit last);
        if (!tx_quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_value     <= v;
        i_last_item <= last;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    // stop offering and wait for every expected result
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // random element: squares, near-squares, small values or any pattern
    function automatic logic [pssf_pkg::VALUE_W-1:0] pick_value(bit all_squares);
        int unsigned sel;
        int unsigned r;
        sel = all_squares ? 0 : $urandom_range(0, 9);
        r   = $urandom_range(2, 46340);
        if (sel < 3)
            return r * r;
        else if (sel == 3)
            return $urandom_range(0, 1) ? r * r + 1 : r * r - 1;
        else if (sel == 4)
            return $urandom_range(0, 8) - 4;
        else
            return $urandom();
    endfunction

    // short arrays of random length until the element count reaches upto
    task automatic run_short_arrays(int upto);
        int len;
        bit all_sq;
        while (sent < upto) begin
            len    = $urandom_range(1, 12);
            all_sq = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < len; k++)
                send_item(pick_value(all_sq), k == len - 1);
        end
    endtask

    // receiver stall bursts, plus one long hold-off on request
    initial begin : rx_side
        int hold_left;
        int burst_left;
        bit stall_on;
        bit hold_used;
        hold_left  = 0;
        burst_left = 0;
        stall_on   = 1'b0;
        hold_used  = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_go && !hold_used) begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
                i_stall <= 1'b1;
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
            end else begin
                if (burst_left == 0) begin
                    stall_on   = ($urandom_range(0, 2) == 0);
                    burst_left = $urandom_range(1, 14);
                end
                burst_left--;
                i_stall <= stall_on;
            end
        end
    end

    // cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= IDLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        int          kept_here;
        int unsigned r;
        logic [pssf_pkg::VALUE_W-1:0] v;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, zero and one, largest in-range square, wrapped squares
        send_item(32'd0, 1'b0);
        send_item(32'd1, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'd2147395600, 1'b0);
        send_item(32'd2147395599, 1'b0);
        send_item(32'd4, 1'b0);
        send_item(32'd2, 1'b0);
        send_item(32'd3, 1'b1);
        // single-element arrays, dropped and kept
        send_item(32'd1, 1'b1);
        send_item(-32'sd7, 1'b1);
        // array with nothing kept
        send_item(32'd9, 1'b0);
        send_item(32'd16, 1'b0);
        send_item(32'd65536, 1'b0);
        send_item(32'd25, 1'b1);
        send_item(32'd0, 1'b1);
        // squares of roots past the int range read as negative, so kept
        send_item(32'd2147488281, 1'b0);
        send_item(32'hFFFE_0001, 1'b1);

        // random arrays, long receiver hold while the sender keeps offering
        run_short_arrays(200);
        tx_quiet = 1'b1;
        hold_go  = 1'b1;
        run_short_arrays(225);
        tx_quiet = 1'b0;
        run_short_arrays(350);
        wait_drained();
        run_short_arrays(500);

        // one long array so the kept counter saturates
        kept_here = 0;
        while (kept_here < 1030) begin
            r = $urandom_range(1, 46340);
            if ($urandom_range(0, 49) == 0) begin
                v = r * r;
            end else begin
                case ($urandom_range(0, 2))
                    0: v = $urandom() | 32'h8000_0000;
                    1: v = r * r + 1;
                    default: v = 32'd0;
                endcase
                kept_here++;
            end
            send_item(v, kept_here >= 1030);
        end

        run_short_arrays(1600);
        // no idling on either side for the last stretch
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_short_arrays(1750);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
